FILE: rtl/vertex_dedup_indexer_unit_defines.svh
// ---------------------------------------------------------------------------
// Vertex dedup indexer assertion macros
// Shared property forms for the checks at the end of the top-level indexer module.
// ---------------------------------------------------------------------------
`ifndef VERTEX_DEDUP_INDEXER_UNIT_DEFINES_SVH
`define VERTEX_DEDUP_INDEXER_UNIT_DEFINES_SVH

// same-cycle implication
`define VDI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vertex dedup indexer check failed");

// next-cycle implication
`define VDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vertex dedup indexer check failed");

`endif

FILE: rtl/vdi_pkg.sv
// ---------------------------------------------------------------------------
// Vertex dedup indexer package
// Types, sizes and codes shared by the indexer modules.
// ---------------------------------------------------------------------------
package vdi_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int INDEX_LIMIT  = 65535;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W        = 12;
  localparam int EPS_W        = 31;
  localparam int WIN_W        = 13;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 31;
  localparam int COMP_W       = 32;
  localparam int LANES        = 8;

  localparam logic [CNT_W-1:0] CAPACITY =
    CNT_W'((MAX_VERTICES > INDEX_LIMIT - 1) ? INDEX_LIMIT - 1 : MAX_VERTICES);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_EPSILON       = 2'd0,
    CFG_WINDOW        = 2'd1,
    CFG_USE_NORMALS   = 2'd2,
    CFG_USE_TEXCOORDS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] pos_x;
    logic signed [COMP_W-1:0] pos_y;
    logic signed [COMP_W-1:0] pos_z;
    logic signed [COMP_W-1:0] norm_x;
    logic signed [COMP_W-1:0] norm_y;
    logic signed [COMP_W-1:0] norm_z;
    logic signed [COMP_W-1:0] tex_s;
    logic signed [COMP_W-1:0] tex_t;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             is_new;
    logic             store_full;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] idx;
  } scan_tag_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [ADDR_W-1:0] idx;
  } match_t;

  typedef struct packed {
    logic              en;
    logic              norm_en;
    logic              tex_en;
    logic [ADDR_W-1:0] addr;
  } store_wr_t;

endpackage

FILE: rtl/vdi_store.sv
// ---------------------------------------------------------------------------
// Vertex store
// Position, normal and texture memories with one write and one registered
// read port; the scan tag travels alongside the read data.
// ---------------------------------------------------------------------------
module vdi_store (
  input  logic                clk,
  input  logic                rst,
  input  vdi_pkg::store_wr_t  wr,
  input  vdi_pkg::in_t        wr_data,
  input  vdi_pkg::scan_tag_t  rd_req,
  input  logic                flush,
  output vdi_pkg::in_t        rd_data,
  output vdi_pkg::scan_tag_t  rd_tag
);

  logic [3*vdi_pkg::COMP_W-1:0] pos_mem  [vdi_pkg::MAX_VERTICES];
  logic [3*vdi_pkg::COMP_W-1:0] norm_mem [vdi_pkg::MAX_VERTICES];
  logic [2*vdi_pkg::COMP_W-1:0] tex_mem  [vdi_pkg::MAX_VERTICES];

  logic [3*vdi_pkg::COMP_W-1:0] pos_q;
  logic [3*vdi_pkg::COMP_W-1:0] norm_q;
  logic [2*vdi_pkg::COMP_W-1:0] tex_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      pos_mem[wr.addr] <= {wr_data.pos_x, wr_data.pos_y, wr_data.pos_z};
    end
    if (wr.en && wr.norm_en) begin
      norm_mem[wr.addr] <= {wr_data.norm_x, wr_data.norm_y, wr_data.norm_z};
    end
    if (wr.en && wr.tex_en) begin
      tex_mem[wr.addr] <= {wr_data.tex_s, wr_data.tex_t};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.valid) begin
      pos_q  <= pos_mem[rd_req.idx];
      norm_q <= norm_mem[rd_req.idx];
      tex_q  <= tex_mem[rd_req.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag.valid <= 1'b0;
    end else begin
      rd_tag.valid <= rd_req.valid && !flush;
    end
    rd_tag.idx <= rd_req.idx;
  end

  assign rd_data = {pos_q, norm_q, tex_q};

endmodule

FILE: rtl/vdi_match_unit.sv
// ---------------------------------------------------------------------------
// Vertex match unit
// Two-stage compare of one stored entry against the request: lane
// differences, then tolerance check and mode masking.
// ---------------------------------------------------------------------------
module vdi_match_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  vdi_pkg::in_t                  rd_data,
  input  vdi_pkg::scan_tag_t            rd_tag,
  input  vdi_pkg::in_t                  item,
  input  logic [vdi_pkg::EPS_W-1:0]     epsilon,
  input  logic                          use_normals,
  input  logic                          use_texcoords,
  input  logic                          flush,
  output vdi_pkg::match_t               res,
  output logic                          pending
);

  logic signed [vdi_pkg::COMP_W-1:0] lane_a [vdi_pkg::LANES];
  logic signed [vdi_pkg::COMP_W-1:0] lane_b [vdi_pkg::LANES];
  logic signed [vdi_pkg::COMP_W:0]   diff   [vdi_pkg::LANES];
  logic        [vdi_pkg::LANES-1:0]  close;
  vdi_pkg::scan_tag_t                diff_tag;
  logic signed [vdi_pkg::COMP_W:0]   eps_pos;
  logic signed [vdi_pkg::COMP_W:0]   eps_neg;
  logic                              hit;

  assign lane_a[0] = rd_data.pos_x;
  assign lane_a[1] = rd_data.pos_y;
  assign lane_a[2] = rd_data.pos_z;
  assign lane_a[3] = rd_data.norm_x;
  assign lane_a[4] = rd_data.norm_y;
  assign lane_a[5] = rd_data.norm_z;
  assign lane_a[6] = rd_data.tex_s;
  assign lane_a[7] = rd_data.tex_t;

  assign lane_b[0] = item.pos_x;
  assign lane_b[1] = item.pos_y;
  assign lane_b[2] = item.pos_z;
  assign lane_b[3] = item.norm_x;
  assign lane_b[4] = item.norm_y;
  assign lane_b[5] = item.norm_z;
  assign lane_b[6] = item.tex_s;
  assign lane_b[7] = item.tex_t;

  always_ff @(posedge clk) begin
    for (int k = 0; k < vdi_pkg::LANES; k++) begin
      diff[k] <= $signed({lane_a[k][vdi_pkg::COMP_W-1], lane_a[k]})
               - $signed({lane_b[k][vdi_pkg::COMP_W-1], lane_b[k]});
    end
  end

  assign eps_pos = $signed({2'b00, epsilon});
  assign eps_neg = -eps_pos;

  always_comb begin
    for (int k = 0; k < vdi_pkg::LANES; k++) begin
      close[k] = (diff[k] <= eps_pos) && (diff[k] >= eps_neg);
    end
    hit = (&close[2:0])
       && (!use_normals || (&close[5:3]))
       && (!use_texcoords || (&close[7:6]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_tag.valid <= 1'b0;
      res.valid      <= 1'b0;
    end else begin
      diff_tag.valid <= rd_tag.valid && !flush;
      res.valid      <= diff_tag.valid && !flush;
    end
    diff_tag.idx <= rd_tag.idx;
    res.hit      <= hit;
    res.idx      <= diff_tag.idx;
  end

  assign pending = diff_tag.valid;

endmodule

FILE: rtl/vertex_dedup_indexer_unit.sv
// ---------------------------------------------------------------------------
// Vertex dedup indexer
// Welds incoming vertices against a store of earlier ones and returns an
// index per vertex.
// ---------------------------------------------------------------------------
// Usage:
//   Requests (one vertex, eight signed Q16.16 components) enter on
//   in_valid/in_ready; one result per request leaves on out_valid/out_ready.
//   Configuration is written on cfg_we/cfg_addr/cfg_wdata while idle.
//   A request scans the stored entries in ascending order, one entry per
//   cycle through the single memory read port feeding the compare pipeline.
//   Up to 4096 entries are scanned, or only the newest ones within the
//   search window when it is nonzero; a match ends the scan early.
//   The next request is taken in the cycle after the result is loaded,
//   even while that result still waits in the output register; the next
//   result is held back until that register is free.
//   Reset empties the store (count to zero), sets epsilon and window to
//   zero and turns normal and texture compare on.
// ---------------------------------------------------------------------------
`include "vertex_dedup_indexer_unit_defines.svh"

module vertex_dedup_indexer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vdi_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vdi_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [vdi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [vdi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  vdi_pkg::state_t               state, state_next;
  vdi_pkg::in_t                  item;
  logic [vdi_pkg::EPS_W-1:0]     epsilon;
  logic [vdi_pkg::WIN_W-1:0]     search_window;
  logic                          use_normals;
  logic                          use_texcoords;
  logic [vdi_pkg::CNT_W-1:0]     stored_count, stored_count_next;
  logic [vdi_pkg::CNT_W-1:0]     issue_ptr, issue_ptr_next;
  logic [vdi_pkg::CNT_W-1:0]     scan_start;
  logic                          hit, hit_next;
  logic [vdi_pkg::ADDR_W-1:0]    hit_idx, hit_idx_next;
  logic                          out_load;
  vdi_pkg::out_t                 out_next;
  logic                          accept;
  logic                          issue_done;
  logic                          flush;
  vdi_pkg::scan_tag_t            rd_req;
  vdi_pkg::scan_tag_t            rd_tag;
  vdi_pkg::in_t                  rd_data;
  vdi_pkg::store_wr_t            wr;
  vdi_pkg::match_t               res;
  logic                          pending;

  assign in_ready = (state == vdi_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  assign scan_start = (search_window != '0 && search_window < stored_count)
                    ? stored_count - search_window : '0;
  assign issue_done = (issue_ptr >= stored_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon       <= '0;
      search_window <= '0;
      use_normals   <= 1'b1;
      use_texcoords <= 1'b1;
    end else if (cfg_we) begin
      case (vdi_pkg::cfg_reg_t'(cfg_addr))
        vdi_pkg::CFG_EPSILON:       epsilon       <= cfg_wdata[vdi_pkg::EPS_W-1:0];
        vdi_pkg::CFG_WINDOW:        search_window <= cfg_wdata[vdi_pkg::WIN_W-1:0];
        vdi_pkg::CFG_USE_NORMALS:   use_normals   <= cfg_wdata[0];
        vdi_pkg::CFG_USE_TEXCOORDS: use_texcoords <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= vdi_pkg::S_IDLE;
      stored_count <= '0;
      out_valid    <= 1'b0;
      hit          <= 1'b0;
    end else begin
      state        <= state_next;
      stored_count <= stored_count_next;
      hit          <= hit_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    issue_ptr <= issue_ptr_next;
    hit_idx   <= hit_idx_next;
    if (accept) begin
      item <= in_data;
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

  always_comb begin
    state_next        = state;
    stored_count_next = stored_count;
    issue_ptr_next    = issue_ptr;
    hit_next          = hit;
    hit_idx_next      = hit_idx;
    out_load          = 1'b0;
    out_next          = '0;
    flush             = 1'b1;
    rd_req.valid      = 1'b0;
    rd_req.idx        = issue_ptr[vdi_pkg::ADDR_W-1:0];
    wr.en             = 1'b0;
    wr.norm_en        = use_normals;
    wr.tex_en         = use_texcoords;
    wr.addr           = stored_count[vdi_pkg::ADDR_W-1:0];
    case (state)
      vdi_pkg::S_IDLE: begin
        if (accept) begin
          issue_ptr_next = scan_start;
          hit_next       = 1'b0;
          state_next     = vdi_pkg::S_SCAN;
        end
      end
      vdi_pkg::S_SCAN: begin
        if (res.valid && res.hit) begin
          hit_next     = 1'b1;
          hit_idx_next = res.idx;
          state_next   = vdi_pkg::S_DONE;
        end else begin
          flush = 1'b0;
          if (!issue_done) begin
            rd_req.valid   = 1'b1;
            issue_ptr_next = issue_ptr + 1'b1;
          end else if (!rd_tag.valid && !pending && !res.valid) begin
            state_next = vdi_pkg::S_DONE;
          end
        end
      end
      vdi_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = vdi_pkg::S_IDLE;
          if (hit) begin
            out_next.vertex_index = vdi_pkg::IDX_W'(hit_idx);
          end else if (stored_count >= vdi_pkg::CAPACITY) begin
            out_next.store_full = 1'b1;
          end else begin
            wr.en                 = 1'b1;
            stored_count_next     = stored_count + 1'b1;
            out_next.vertex_index = vdi_pkg::IDX_W'(stored_count);
            out_next.is_new       = 1'b1;
          end
        end
      end
      default: state_next = vdi_pkg::S_IDLE;
    endcase
  end

  vdi_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .wr_data (item),
    .rd_req  (rd_req),
    .flush   (flush),
    .rd_data (rd_data),
    .rd_tag  (rd_tag)
  );

  vdi_match_unit u_match (
    .clk           (clk),
    .rst           (rst),
    .rd_data       (rd_data),
    .rd_tag        (rd_tag),
    .item          (item),
    .epsilon       (epsilon),
    .use_normals   (use_normals),
    .use_texcoords (use_texcoords),
    .flush         (flush),
    .res           (res),
    .pending       (pending)
  );

  `VDI_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, stored_count <= vdi_pkg::CAPACITY)
  `VDI_ASSERT_NOW(a_flags_exclusive, clk, rst, out_valid,
                  !(out_data.is_new && out_data.store_full))
  `VDI_ASSERT_NOW(a_full_means_full, clk, rst, out_valid && out_data.store_full,
                  stored_count == vdi_pkg::CAPACITY)
  `VDI_ASSERT_NEXT(a_append_counts, clk, rst, out_load && out_next.is_new,
                   stored_count == $past(stored_count) + 1'b1)

endmodule
